[rtl/core/ssms_pkg.sv]
package ssms_pkg;

  localparam int unsigned PriceW     = 16;
  localparam int unsigned PosW       = 32;
  localparam int unsigned StackDepth = 1024;

  // One stack entry: price and 1-based item number
  typedef struct packed {
    logic [PriceW-1:0] price;
    logic [PosW-1:0]   position;
  } entry_t;

  // Shift command broadcast to every cell of the chain
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

[rtl/core/ssms_cell.sv]
module ssms_cell (
  input  logic               clk_i,
  input  ssms_pkg::shift_ctl_t ctl_i,
  input  ssms_pkg::entry_t   up_i,
  input  ssms_pkg::entry_t   down_i,
  output ssms_pkg::entry_t   entry_o
);

  ssms_pkg::entry_t entry_q;
  ssms_pkg::entry_t entry_d;

  // Take the neighbor above on push, the one below on pop, else hold
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.push) begin
      entry_d = up_i;
    end else if (ctl_i.pop) begin
      entry_d = down_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[rtl/core/ssms_chain.sv]
module ssms_chain #(
  parameter int unsigned STACK_DEPTH = ssms_pkg::StackDepth
) (
  input  logic                 clk_i,
  input  ssms_pkg::shift_ctl_t ctl_i,
  input  ssms_pkg::entry_t     push_entry_i,
  output ssms_pkg::entry_t     top_o
);

  ssms_pkg::entry_t cell_q [STACK_DEPTH];

  // Row of cells, top at index 0; the bottom entry falls off on a full push
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    ssms_pkg::entry_t up;
    ssms_pkg::entry_t down;

    if (i == 0) begin : g_top
      assign up = push_entry_i;
    end else begin : g_mid_up
      assign up = cell_q[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign down = '0;
    end else begin : g_mid_down
      assign down = cell_q[i+1];
    end

    ssms_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl_i),
      .up_i    (up),
      .down_i  (down),
      .entry_o (cell_q[i])
    );
  end

  assign top_o = cell_q[0];

endmodule

[rtl/core/stock_span_monotonic_stack_top.sv]
// Stock span unit. Each price transfer returns one span: the distance back to the
// most recent earlier price that is strictly greater, or the item count when there
// is none, together with a sticky overflow flag. The monotonic stack lives in a
// chain of STACK_DEPTH cells that all shift by one entry per cycle. An item first pops
// every entry whose price is not above its own, then pushes once; the push waits while
// an earlier span is stalled at the output. A new price is taken in the same
// cycle as the push of the previous one, and while an earlier span still waits to
// be taken. When the stack is full on a push, the oldest entry is lost and overflow
// stays set until reset; later spans may then be too large. No clearing pass is run
// after reset.
module stock_span_monotonic_stack_top #(
  parameter int unsigned STACK_DEPTH = ssms_pkg::StackDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ssms_pkg::PriceW-1:0] price_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ssms_pkg::PosW-1:0]   span_o,
  output logic                        overflow_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  logic                        busy_q, busy_d;
  logic [ssms_pkg::PriceW-1:0] price_q;
  logic [ssms_pkg::PosW-1:0]   number_q;
  logic [ssms_pkg::PosW-1:0]   pos_q;
  logic [CntW-1:0]             count_q, count_d;
  logic                        ovf_q, ovf_d;
  logic                        out_valid_q, out_valid_d;
  logic [ssms_pkg::PosW-1:0]   span_q;
  logic                        out_ovf_q;

  logic                 accept;
  logic                 out_free;
  logic                 stack_full;
  logic                 pop_now;
  logic                 push_now;
  ssms_pkg::shift_ctl_t shift_ctl;
  ssms_pkg::entry_t     push_entry;
  ssms_pkg::entry_t     top;
  logic [ssms_pkg::PosW-1:0] span_d;

  // Decide pop or push for the item in flight
  assign out_free   = !out_valid_q || !out_stall_i;
  assign stack_full = (count_q == CntW'(STACK_DEPTH));
  assign pop_now    = busy_q && (count_q != '0) && (top.price <= price_q);
  assign push_now   = busy_q && !pop_now && out_free;
  assign in_stall_o = busy_q && !push_now;
  assign accept     = in_valid_i && !in_stall_o;

  assign shift_ctl.push = push_now;
  assign shift_ctl.pop  = pop_now;
  assign push_entry.price    = price_q;
  assign push_entry.position = number_q;

  ssms_chain #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_chain (
    .clk_i        (clk_i),
    .ctl_i        (shift_ctl),
    .push_entry_i (push_entry),
    .top_o        (top)
  );

  // Span from the surviving top entry, or the item number on an empty stack
  assign span_d = (count_q != '0) ? (number_q - top.position) : number_q;

  // Advance control state
  always_comb begin
    busy_d      = busy_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_now) begin
      count_d = count_q - CntW'(1);
    end
    if (push_now) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      if (stack_full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end
    if (accept) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  // Hold the item being worked on and the result waiting for transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      price_q  <= price_i;
      number_q <= pos_q + 1'b1;
    end
    if (push_now) begin
      span_q    <= span_d;
      out_ovf_q <= ovf_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign span_o      = span_q;
  assign overflow_o  = out_ovf_q;

  // Stack fill never passes the cell count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(STACK_DEPTH))
    else $error("stack count above depth");

  // A pop never happens on an empty stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_now |-> (count_q != '0))
    else $error("pop on empty stack");

  // Every push leaves a result in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_now |=> out_valid_q)
    else $error("push without result");

  // Overflow stays set once seen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared");

endmodule

[tb/stock_span_checker.sv]
`timescale 1ns / 100ps

module stock_span_checker #(
  parameter int unsigned STACK_DEPTH = ssms_pkg::StackDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [ssms_pkg::PriceW-1:0] price_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [ssms_pkg::PosW-1:0]   span_i,
  input  logic                        overflow_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  typedef struct packed {
    logic [ssms_pkg::PosW-1:0] span;
    logic                      overflow;
  } span_rec_t;

  // Shadow copy of the monotonic stack and the item counter
  logic [ssms_pkg::PriceW-1:0] peak_price [STACK_DEPTH];
  logic [ssms_pkg::PosW-1:0]   peak_pos   [STACK_DEPTH];
  int unsigned                 peak_count;
  logic [ssms_pkg::PosW-1:0]   item_num;
  logic                        ovf_seen;
  span_rec_t                   span_q [$];

  // Pop every entry not above the new price, take the span, push the new pair
  function automatic span_rec_t next_span(input logic [ssms_pkg::PriceW-1:0] price);
    span_rec_t rec;
    item_num = item_num + 1'b1;
    while (peak_count > 0 && peak_price[peak_count-1] <= price) begin
      peak_count--;
    end
    if (peak_count > 0) begin
      rec.span = item_num - peak_pos[peak_count-1];
    end else begin
      rec.span = item_num;
    end
    // Full stack: drop the oldest entry and mark the overflow
    if (peak_count >= STACK_DEPTH) begin
      for (int i = 0; i < STACK_DEPTH - 1; i++) begin
        peak_price[i] = peak_price[i+1];
        peak_pos[i]   = peak_pos[i+1];
      end
      peak_count = STACK_DEPTH - 1;
      ovf_seen   = 1'b1;
    end
    peak_price[peak_count] = price;
    peak_pos[peak_count]   = item_num;
    peak_count++;
    rec.overflow = ovf_seen;
    return rec;
  endfunction

  // Check each result transfer first, then record the prediction for a new price
  always @(posedge clk_i or negedge rst_ni) begin : watch
    span_rec_t want;
    if (!rst_ni) begin
      peak_count = 0;
      item_num   = '0;
      ovf_seen   = 1'b0;
      span_q.delete();
      pending_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (span_q.size() == 0) begin
          $error("unexpected result: span %0d overflow %0d", span_i, overflow_i);
          fail_count_o++;
        end else begin
          want = span_q.pop_front();
          if (span_i !== want.span) begin
            $error("span: expected %0d, actual %0d", want.span, span_i);
            fail_count_o++;
          end
          if (overflow_i !== want.overflow) begin
            $error("overflow: expected %0d, actual %0d", want.overflow, overflow_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        span_q.insert(span_q.size(), next_span(price_i));
      end
      pending_o = span_q.size();
    end
  end

endmodule

[tb/stock_span_monotonic_stack_top_tb.sv]
`timescale 1ns / 100ps

module stock_span_monotonic_stack_top_tb;

  localparam int unsigned Depth       = ssms_pkg::StackDepth;
  localparam int          RandomItems = 80;

  typedef logic [ssms_pkg::PriceW-1:0] price_t;

  typedef enum int {
    RunFall,
    RunRise,
    RunFlat,
    RunSaw,
    RunExtreme,
    RunNoise
  } run_kind_e;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  logic [ssms_pkg::PriceW-1:0] price     = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [ssms_pkg::PosW-1:0]   span;
  logic                        overflow;
  int                          fail_count;
  int                          pending;
  int                          send_idle_pct = 0;
  int                          stall_pct     = 0;

  logic [ssms_pkg::PriceW-1:0] corner_prices [20] = '{
    16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 16'h0002, 16'h0003,
    16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 16'd100, 16'd50, 16'd75, 16'd75,
    16'd60, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFE
  };

  stock_span_monotonic_stack_top #(
    .STACK_DEPTH(Depth)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .price_i    (price),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .span_o     (span),
    .overflow_o (overflow)
  );

  stock_span_checker #(
    .STACK_DEPTH(Depth)
  ) checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .price_i     (price),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .span_i      (span),
    .overflow_i  (overflow),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #2 clk = ~clk;

  // Stall the result side at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Idle for a random gap, then hold the price until its transfer
  task automatic send_price(input logic [ssms_pkg::PriceW-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    price    <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold off new prices until every span has come back
  task automatic drain_spans();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Send shaped runs of prices: falls build the stack, rises and flats pop it
  task automatic send_runs(input int n_items);
    int                          sent;
    int                          len;
    run_kind_e                   kind;
    logic [ssms_pkg::PriceW-1:0] p;
    sent = 0;
    while (sent < n_items) begin
      kind = run_kind_e'($urandom_range(5));
      len  = $urandom_range(2, 24);
      p    = price_t'($urandom);
      for (int i = 0; i < len; i++) begin
        case (kind)
          RunFall: begin
            if (i > 0) p = price_t'(p - $urandom_range(1, 300));
          end
          RunRise: begin
            if (i > 0) p = price_t'(p + $urandom_range(0, 300));
          end
          RunFlat: begin
            if ($urandom_range(3) == 0) begin
              p = price_t'(p + $urandom_range(1) - $urandom_range(1));
            end
          end
          RunSaw: begin
            if (i[0]) p = price_t'(p + $urandom_range(1, 500));
            else p = price_t'(p - $urandom_range(1, 800));
          end
          RunExtreme: begin
            case ($urandom_range(3))
              0: p = 16'h0000;
              1: p = 16'h0001;
              2: p = 16'hFFFE;
              default: p = 16'hFFFF;
            endcase
          end
          default: p = price_t'($urandom);
        endcase
        send_price(p);
        sent++;
      end
      if ($urandom_range(39) == 0) drain_spans();
    end
  endtask

  initial begin : stimulus
    logic [ssms_pkg::PriceW-1:0] fall_price;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Extremes, equal prices and partial pops
    foreach (corner_prices[i]) send_price(corner_prices[i]);
    drain_spans();

    // Random runs under each idle and stall pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 69; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 69; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      send_runs(RandomItems / 4);
      drain_spans();
    end

    // Strictly falling run past the stack depth to force the overflow
    send_idle_pct = 0;
    stall_pct     = 21;
    fall_price    = 16'd64000;
    for (int i = 0; i < Depth + 40; i++) begin
      send_price(fall_price);
      fall_price = price_t'(fall_price - $urandom_range(1, 2));
    end
    // Keep going after the overflow so lost entries show up in the spans
    send_idle_pct = 21;
    send_runs(60);
    drain_spans();

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
